>>> design/bdlp_pkg.sv
// Package for the button debounce and long-press block.
// Holds configuration codes, reset values and the types shared between modules.
// No dependencies.
package bdlp_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int TIME_BITS_DEFAULT = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG_PRESS = 2'd1;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET   = 16'd5;
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RESET = 16'd300;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] debounce_ticks;
        logic [CFG_DATA_W-1:0] long_press_ticks;
    } t_cfg;

    typedef struct packed {
        logic short_press;
        logic long_press;
    } t_result;

endpackage

>>> design/bdlp_if.sv
// Handshake channel interfaces for the button debounce block.
// bdlp_in_if carries pin samples, bdlp_out_if carries press events. No dependencies.
interface bdlp_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink (input valid, input button_level, output ready);
endinterface

interface bdlp_out_if;
    logic valid;
    logic ready;
    logic short_press;
    logic long_press;

    modport source (output valid, output short_press, output long_press, input ready);
    modport sink (input valid, input short_press, input long_press, output ready);
endinterface

>>> design/bdlp_cfg.sv
// Configuration registers: debounce time and long-press time in poll ticks.
// Depends on bdlp_pkg.
module bdlp_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output bdlp_pkg::t_cfg                      o_cfg
);
    import bdlp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= DEBOUNCE_RESET;
            r_cfg.long_press_ticks <= LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_DEBOUNCE:   r_cfg.debounce_ticks   <= i_cfg_data;
                CFG_IDX_LONG_PRESS: r_cfg.long_press_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/bdlp_core.sv
// Press detector: tick counter, timestamps and press flags, one sample per advance.
// Depends on bdlp_pkg.
module bdlp_core #(
    parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_level,
    input  bdlp_pkg::t_cfg     i_cfg,
    output bdlp_pkg::t_result  o_res
);
    import bdlp_pkg::*;

    logic                 r_prev;
    logic                 r_held;
    logic                 r_long_rep;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_fall;
    // accept time and hold start are always loaded together, so one register serves both
    logic [TIME_BITS-1:0] r_acc;

    logic [TIME_BITS-1:0] n_fall;
    logic [TIME_BITS-1:0] n_acc;
    logic                 n_held;
    logic                 n_long_rep;
    logic [TIME_BITS-1:0] deb;
    logic [TIME_BITS-1:0] lng;
    logic [TIME_BITS-1:0] since_fall;
    logic [TIME_BITS-1:0] since_acc;
    logic [TIME_BITS-1:0] since_hold;
    logic                 press;
    logic                 held_a;
    logic                 rep_a;
    logic                 rise;

    always_comb begin
        deb = {{(TIME_BITS-CFG_DATA_W){1'b0}}, i_cfg.debounce_ticks};
        lng = {{(TIME_BITS-CFG_DATA_W){1'b0}}, i_cfg.long_press_ticks};

        n_fall     = (r_prev && !i_level && !r_held) ? r_now : r_fall;
        since_fall = r_now - n_fall;
        since_acc  = r_now - r_acc;
        press      = !i_level && !r_held && (since_fall >= deb) && (since_acc > deb);

        n_acc      = press ? r_now : r_acc;
        held_a     = r_held | press;
        rep_a      = press ? 1'b0 : r_long_rep;
        since_hold = r_now - n_acc;

        o_res.long_press  = held_a && !i_level && !rep_a && (since_hold >= lng);
        rise              = !r_prev && i_level && held_a;
        o_res.short_press = rise && !rep_a;

        // release drops the press and its long flag
        n_held     = rise ? 1'b0 : held_a;
        n_long_rep = rise ? 1'b0 : (rep_a | o_res.long_press);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= 1'b1;
            r_held     <= 1'b0;
            r_long_rep <= 1'b0;
            r_now      <= '0;
            r_fall     <= '0;
            r_acc      <= '0;
        end else if (i_adv) begin
            r_prev     <= i_level;
            r_held     <= n_held;
            r_long_rep <= n_long_rep;
            r_now      <= r_now + {{(TIME_BITS-1){1'b0}}, 1'b1};
            r_fall     <= n_fall;
            r_acc      <= n_acc;
        end
    end

`ifndef SYNTHESIS
    a_rep_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_long_rep |-> r_held)
        else $error("long-press flag set without a held press");

    a_short_ends_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.short_press) |=> !r_held)
        else $error("press still held after short-press beat");

    a_long_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.long_press) |=> r_long_rep)
        else $error("long-press flag not set after long-press beat");
`endif

endmodule

>>> design/button_debounce_long_press.sv
// Button debounce with long-press detection.
// Channels: i_btn takes one pin sample (button_level, 0 = pressed) per beat;
// o_evt gives exactly one event beat per sample with short_press and
// long_press, both 0 when nothing happened. Each sample is one poll tick.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 = debounce ticks, 1 = long-press ticks); other indexes are ignored.
// Write only while no sample is in flight.
// Pipeline: a sample passes the input register, then the result register,
// before its event shows on o_evt. Throughput: one sample per cycle while
// o_evt.ready is high; the path from input register to result register is
// a few subtract-and-compare steps over TIME_BITS.
// Reset: tick count and timestamps clear to 0, level reads as released,
// debounce = 5, long press = 300 ticks.
// Stall: when o_evt.ready is low the result register holds and the input
// register still takes one more sample; i_btn.ready drops only when both
// are full.
// Depends on bdlp_pkg, bdlp_if, bdlp_cfg and bdlp_core.
module button_debounce_long_press #(
    parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bdlp_in_if.sink                          i_btn,
    bdlp_out_if.source                       o_evt,
    input  logic                             i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bdlp_pkg::*;

    t_cfg    cfg;
    t_result res;
    logic    adv;

    logic    r_in_valid;
    logic    r_in_level;
    logic    r_out_valid;
    t_result r_out;

    bdlp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bdlp_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_level (r_in_level),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // advance when a sample waits and the result register is free or draining
    assign adv         = r_in_valid && (!r_out_valid || o_evt.ready);
    assign i_btn.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_btn.valid && i_btn.ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_btn.valid && i_btn.ready) begin
            r_in_level <= i_btn.button_level;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_evt.valid       = r_out_valid;
    assign o_evt.short_press = r_out.short_press;
    assign o_evt.long_press  = r_out.long_press;

`ifndef SYNTHESIS
    a_one_event_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.valid |-> !(o_evt.short_press && o_evt.long_press))
        else $error("short and long press in one beat");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_btn.ready)
        else $error("input stalled with empty result register");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && !o_evt.ready) |=>
            (o_evt.valid && $stable({o_evt.short_press, o_evt.long_press})))
        else $error("event beat changed while stalled");
`endif

endmodule
